[rtl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed by the register map
    localparam int PATTERN_BYTES  = 16;
    localparam int LEN_W          = 5;
    localparam int MATCH_OFFSET_W = 32;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 8'd0,
        REG_PATTERN_HIGH   = 8'd1,
        REG_WILDCARD_MASK  = 8'd2,
        REG_PATTERN_LENGTH = 8'd3
    } wbps_reg_idx_t;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   wildcard_mask;
        logic [LEN_W-1:0]           pattern_length;
    } wbps_cfg_t;

    typedef struct packed {
        logic                      emit;
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } wbps_result_t;

endpackage

[rtl/wbps_match.sv]
// ----------------------------------------------------------------------------
// wbps_match
// Parallel compare of the byte history against the pattern with wildcards.
// ----------------------------------------------------------------------------
module wbps_match
    import wbps_pkg::*;
#(
    parameter int EFF_MAX = 16,
    parameter int WIN_D   = 15
) (
    input  logic [7:0]                 cur_byte,
    input  logic [7:0]                 win [WIN_D],
    input  logic [LEN_W-1:0]           len_m1,
    input  logic [8*PATTERN_BYTES-1:0] pattern,
    input  logic [PATTERN_BYTES-1:0]   wildcard_mask,
    output logic                       hit
);

    localparam int HIST_IW = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int HIST_D  = 1 << HIST_IW;

    // hist[k] is the byte k steps back, the current byte at zero
    logic [7:0]         hist [HIST_D];
    logic [EFF_MAX-1:0] byte_ok;

    assign hist[0] = cur_byte;

    genvar k, j;
    generate
        for (k = 1; k < HIST_D; k++) begin : g_hist
            if (k < EFF_MAX && k <= WIN_D) begin : g_tap
                assign hist[k] = win[k-1];
            end else begin : g_pad
                assign hist[k] = 8'd0;
            end
        end

        for (j = 0; j < EFF_MAX; j++) begin : g_cmp
            logic             active;
            logic [LEN_W-1:0] back;
            assign active     = (LEN_W'(j) <= len_m1);
            assign back       = len_m1 - LEN_W'(j);
            assign byte_ok[j] = !active || wildcard_mask[j] ||
                                (hist[back[HIST_IW-1:0]] == pattern[8*j +: 8]);
        end
    endgenerate

    assign hit = &byte_ok;

endmodule

[rtl/wbps_track.sv]
// ----------------------------------------------------------------------------
// wbps_track
// Region state: byte window, saturating offset counter and done flag.
// ----------------------------------------------------------------------------
module wbps_track
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  wbps_cfg_t    cfg,
    input  logic         step,
    input  logic [7:0]   cur_byte,
    input  logic         cur_last,
    output wbps_result_t result
);

    localparam int EFF_MAX = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
    localparam int WIN_D   = (EFF_MAX > 1) ? EFF_MAX - 1 : 1;

    logic [7:0]             win_reg [WIN_D];
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   done_reg, done_next;

    logic [LEN_W-1:0]                   len, len_m1;
    logic                               full, hit, found;
    logic [OFFSET_BITS-1:0]             len_m1_ext, diff;
    logic [MATCH_OFFSET_W+OFFSET_BITS-1:0] diff_ext;

    always_comb begin
        if (cfg.pattern_length == '0) begin
            len = LEN_W'(1);
        end else if (cfg.pattern_length > LEN_W'(EFF_MAX)) begin
            len = LEN_W'(EFF_MAX);
        end else begin
            len = cfg.pattern_length;
        end
    end

    assign len_m1     = len - LEN_W'(1);
    assign len_m1_ext = {{(OFFSET_BITS-LEN_W){1'b0}}, len_m1};
    assign full       = (count_reg >= len_m1_ext);
    assign diff       = count_reg - len_m1_ext;
    assign diff_ext   = {{MATCH_OFFSET_W{1'b0}}, diff};

    wbps_match #(
        .EFF_MAX (EFF_MAX),
        .WIN_D   (WIN_D)
    ) u_match (
        .cur_byte      (cur_byte),
        .win           (win_reg),
        .len_m1        (len_m1),
        .pattern       (cfg.pattern),
        .wildcard_mask (cfg.wildcard_mask),
        .hit           (hit)
    );

    assign found               = !done_reg && full && hit;
    assign result.emit         = !done_reg && (found || cur_last);
    assign result.found        = found;
    assign result.match_offset = found ? diff_ext[MATCH_OFFSET_W-1:0] : '0;

    always_comb begin
        count_next = count_reg;
        done_next  = done_reg;
        if (!done_reg) begin
            if (count_reg != '1) begin
                count_next = count_reg + OFFSET_BITS'(1);
            end
            done_next = found;
        end
        // last beat closes the region
        if (cur_last) begin
            count_next = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else if (step) begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // entries are only read once written in the current region
    always_ff @(posedge aclk) begin
        if (step && !done_reg) begin
            win_reg[0] <= cur_byte;
            for (int k = 1; k < WIN_D; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

endmodule

[rtl/wildcard_byte_pattern_scanner.sv]
// An input beat passes the input register, then the result register.
// Throughput: one byte per cycle, set by the single compare stage between
// the two registers; a stalled result register holds off the input. Reset
// (aresetn, synchronous, active low) empties both stages, clears the region
// state and loads the pattern registers with zero and the pattern length
// with one.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Finds the first offset in a byte region where a wildcard pattern matches.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      s_last_byte,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [MATCH_OFFSET_W-1:0] m_match_offset,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    wbps_cfg_t    cfg_reg;
    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    logic         out_valid_reg, out_valid_next;
    logic         out_found_reg;
    logic [MATCH_OFFSET_W-1:0] out_offset_reg;
    logic         out_free, step;
    wbps_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern        <= '0;
            cfg_reg.wildcard_mask  <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PATTERN_LOW: begin
                    cfg_reg.pattern[CFG_DATA_W-1:0] <= cfg_data;
                end
                REG_PATTERN_HIGH: begin
                    cfg_reg.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
                end
                REG_WILDCARD_MASK: begin
                    cfg_reg.wildcard_mask <= cfg_data[PATTERN_BYTES-1:0];
                end
                REG_PATTERN_LENGTH: begin
                    cfg_reg.pattern_length <= cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    wbps_track #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .step     (step),
        .cur_byte (in_data_reg),
        .cur_last (in_last_reg),
        .result   (result)
    );

    always_comb begin
        if (step) begin
            out_valid_next = result.emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload loads only with a beat that produces one
    always_ff @(posedge aclk) begin
        if (step && result.emit) begin
            out_found_reg  <= result.found;
            out_offset_reg <= result.match_offset;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_match_offset = out_offset_reg;

endmodule
